// ----- src/tbfm_pkg.sv -----
// ----------------------------------------------------------------------------
// tbfm_pkg
// Shared widths, constants, codes and the command type passed from the
// front end to the buffer control back end of the triple buffer manager.
// ----------------------------------------------------------------------------
package tbfm_pkg;

	localparam int DIM_W        = 13;
	localparam int PROD_W       = 2 * DIM_W;
	localparam int IDX_W        = 24;
	localparam int BUF_W        = 2;
	localparam int NUM_BUFFERS  = 3;
	localparam int CNT_W        = 32;
	localparam int LUMA_W       = 8;
	localparam int COLOR_W      = 8;
	localparam int OP_W         = 2;
	localparam int CFG_IDX_W    = 1;
	localparam int QUEUE_DEPTH  = 2;

	localparam int MAX_DIMENSION_DEF = 4096;
	localparam logic [DIM_W-1:0] DEF_WIDTH  = DIM_W'(1920);
	localparam logic [DIM_W-1:0] DEF_HEIGHT = DIM_W'(1080);
	localparam logic [DIM_W-1:0] PROBE_POS  = DIM_W'(12);

	// bt.601 style weights, sum of the three is 256
	localparam int LUMA_R = 77;
	localparam int LUMA_G = 150;
	localparam int LUMA_B = 29;
	localparam int LUMA_SUM_W = COLOR_W + 8;

	// input op codes
	localparam logic [OP_W-1:0] OP_PIXEL     = 2'd0;
	localparam logic [OP_W-1:0] OP_PRESENT   = 2'd1;
	localparam logic [OP_W-1:0] OP_SRC_RESET = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// writing buffer after reset
	localparam logic [BUF_W-1:0] WRITE_BUF_RESET = 2'd1;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_PIXEL,
		CMD_PRESENT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [IDX_W-1:0]   index;
		logic               hit_center;
		logic               hit_probe;
		logic               last;
		logic [LUMA_W-1:0]  luma;
	} cmd_t;

endpackage

// ----- src/triple_buffer_frame_manager.sv -----
// ----------------------------------------------------------------------------
// triple_buffer_frame_manager
// Three-buffer rotation for a raw rgba pixel stream with center and probe
// luma capture and frame, present and drop counters.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    op, red, green, blue, alpha
//  out       source     out_valid / out_stall  write_valid .. dropped_count
//  cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained unless out_stall or a geometry recompute holds
// the flow, one result per item (front classify into queue, back update into
// the result register). after reset and after each geometry write the input
// stalls while the frame size, center and probe positions are recomputed.
// a two-entry queue lets the input keep moving while a result waits on
// out_stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
module triple_buffer_frame_manager #(
	parameter int MAX_DIMENSION = tbfm_pkg::MAX_DIMENSION_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tbfm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbfm_pkg::DIM_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tbfm_pkg::OP_W-1:0]       op,
	input  logic [tbfm_pkg::COLOR_W-1:0]    red,
	input  logic [tbfm_pkg::COLOR_W-1:0]    green,
	input  logic [tbfm_pkg::COLOR_W-1:0]    blue,
	input  logic [tbfm_pkg::COLOR_W-1:0]    alpha,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            write_valid,
	output logic [tbfm_pkg::BUF_W-1:0]      write_buffer,
	output logic [tbfm_pkg::IDX_W-1:0]      pixel_index,
	output logic                            frame_done,
	output logic [tbfm_pkg::BUF_W-1:0]      present_buffer,
	output logic [tbfm_pkg::LUMA_W-1:0]     luma_center,
	output logic [tbfm_pkg::LUMA_W-1:0]     luma_probe,
	output logic [tbfm_pkg::CNT_W-1:0]      frames_completed,
	output logic [tbfm_pkg::CNT_W-1:0]      presented_count,
	output logic [tbfm_pkg::CNT_W-1:0]      dropped_count
);
	import tbfm_pkg::*;

	logic push, pop, queue_full, queue_empty;
	cmd_t push_cmd, head_cmd;

	// alpha is accepted on the input but not used inside this block
	assign cfg_ready = 1'b1;

	tbfm_front #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	tbfm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	tbfm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_cmd         (head_cmd),
		.empty            (queue_empty),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.write_valid      (write_valid),
		.write_buffer     (write_buffer),
		.pixel_index      (pixel_index),
		.frame_done       (frame_done),
		.present_buffer   (present_buffer),
		.luma_center      (luma_center),
		.luma_probe       (luma_probe),
		.frames_completed (frames_completed),
		.presented_count  (presented_count),
		.dropped_count    (dropped_count)
	);

endmodule

// ----- src/tbfm_front.sv -----
// ----------------------------------------------------------------------------
// tbfm_front
// Geometry registers and derived frame positions, running pixel index,
// luma computation and classification of each accepted item.
// ----------------------------------------------------------------------------
module tbfm_front #(
	parameter int MAX_DIMENSION = tbfm_pkg::MAX_DIMENSION_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [tbfm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbfm_pkg::DIM_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tbfm_pkg::OP_W-1:0]       op,
	input  logic [tbfm_pkg::COLOR_W-1:0]    red,
	input  logic [tbfm_pkg::COLOR_W-1:0]    green,
	input  logic [tbfm_pkg::COLOR_W-1:0]    blue,
	input  logic                            queue_full,
	output logic                            push,
	output tbfm_pkg::cmd_t                  push_cmd
);
	import tbfm_pkg::*;

	localparam int DIM_MAX_V = (1 << DIM_W) - 1;
	localparam logic [DIM_W-1:0] MAX_DIM_C =
		DIM_W'((MAX_DIMENSION > DIM_MAX_V) ? DIM_MAX_V : MAX_DIMENSION);
	localparam int GEO_LAT = 2;
	localparam int BUSY_W = $clog2(GEO_LAT + 1);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > MAX_DIM_C)
			r = MAX_DIM_C;
		return r;
	endfunction

	logic [DIM_W-1:0]  width_q, height_q;
	logic [BUSY_W-1:0] geo_busy_q;
	logic [PROD_W-1:0] total_prod_q, center_prod_q, probe_prod_q;
	logic [PROD_W-1:0] total_q, center_q, probe_q;
	logic [DIM_W-1:0]  probe_x, probe_y;
	logic [IDX_W-1:0]  pixel_offset_q;
	logic [PROD_W-1:0] idx_ext, idx_next_ext;
	logic [LUMA_SUM_W-1:0] luma_sum;
	logic              is_last;

	// geometry, clamped as it is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= DEF_WIDTH;
			height_q   <= DEF_HEIGHT;
			geo_busy_q <= BUSY_W'(GEO_LAT);
		end else if (cfg_valid) begin
			if (cfg_index == REG_FRAME_WIDTH)
				width_q <= clamp_dim(cfg_data);
			if (cfg_index == REG_FRAME_HEIGHT)
				height_q <= clamp_dim(cfg_data);
			geo_busy_q <= BUSY_W'(GEO_LAT);
		end else if (geo_busy_q != '0) begin
			geo_busy_q <= geo_busy_q - BUSY_W'(1);
		end
	end

	assign probe_x = (width_q > PROBE_POS) ? PROBE_POS : width_q - DIM_W'(1);
	assign probe_y = (height_q > PROBE_POS) ? PROBE_POS : height_q - DIM_W'(1);

	// two stage derivation: products, then offsets added
	always_ff @(posedge clk) begin
		total_prod_q  <= PROD_W'(width_q) * PROD_W'(height_q);
		center_prod_q <= PROD_W'(height_q >> 1) * PROD_W'(width_q);
		probe_prod_q  <= PROD_W'(probe_y) * PROD_W'(width_q);
		total_q       <= total_prod_q;
		center_q      <= center_prod_q + PROD_W'(width_q >> 1);
		probe_q       <= probe_prod_q + PROD_W'(probe_x);
	end

	assign in_stall = (geo_busy_q != '0) || queue_full;
	assign push     = in_valid && !in_stall;

	assign idx_ext      = PROD_W'(pixel_offset_q);
	assign idx_next_ext = idx_ext + PROD_W'(1);
	assign is_last      = idx_next_ext >= total_q;
	assign luma_sum     = LUMA_SUM_W'(LUMA_R) * LUMA_SUM_W'(red)
		+ LUMA_SUM_W'(LUMA_G) * LUMA_SUM_W'(green)
		+ LUMA_SUM_W'(LUMA_B) * LUMA_SUM_W'(blue);

	always_comb begin
		push_cmd            = '0;
		push_cmd.kind       = CMD_NONE;
		push_cmd.index      = pixel_offset_q;
		push_cmd.hit_center = idx_ext == center_q;
		push_cmd.hit_probe  = idx_ext == probe_q;
		push_cmd.last       = is_last;
		push_cmd.luma       = luma_sum[LUMA_SUM_W-1 -: LUMA_W];
		unique case (op)
			OP_PIXEL:   push_cmd.kind = CMD_PIXEL;
			OP_PRESENT: push_cmd.kind = CMD_PRESENT;
			default:    push_cmd.kind = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_offset_q <= '0;
		end else if (push) begin
			if (op == OP_PIXEL)
				pixel_offset_q <= is_last ? '0 : idx_next_ext[IDX_W-1:0];
			else if (op == OP_SRC_RESET)
				pixel_offset_q <= '0;
		end
	end

endmodule

// ----- src/tbfm_queue.sv -----
// ----------------------------------------------------------------------------
// tbfm_queue
// Short command queue between the front end and the buffer control back end.
// ----------------------------------------------------------------------------
module tbfm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tbfm_pkg::cmd_t push_cmd,
	input  logic           pop,
	output tbfm_pkg::cmd_t head_cmd,
	output logic           full,
	output logic           empty
);
	import tbfm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full     = count_q == CNT_QW'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_QW'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_QW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_QW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

// ----- src/tbfm_back.sv -----
// ----------------------------------------------------------------------------
// tbfm_back
// Buffer rotation, luma publication and frame counters; one command per
// cycle into the registered result stage while out_stall does not hold it.
// ----------------------------------------------------------------------------
module tbfm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tbfm_pkg::cmd_t                head_cmd,
	input  logic                          empty,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          write_valid,
	output logic [tbfm_pkg::BUF_W-1:0]    write_buffer,
	output logic [tbfm_pkg::IDX_W-1:0]    pixel_index,
	output logic                          frame_done,
	output logic [tbfm_pkg::BUF_W-1:0]    present_buffer,
	output logic [tbfm_pkg::LUMA_W-1:0]   luma_center,
	output logic [tbfm_pkg::LUMA_W-1:0]   luma_probe,
	output logic [tbfm_pkg::CNT_W-1:0]    frames_completed,
	output logic [tbfm_pkg::CNT_W-1:0]    presented_count,
	output logic [tbfm_pkg::CNT_W-1:0]    dropped_count
);
	import tbfm_pkg::*;

	// lowest buffer that is neither presented nor ready
	function automatic logic [BUF_W-1:0] pick_free(input logic [BUF_W-1:0] a,
			input logic [BUF_W-1:0] b);
		logic [BUF_W-1:0] r;
		r = '0;
		for (int c = NUM_BUFFERS - 1; c >= 0; c--) begin
			if (BUF_W'(c) != a && BUF_W'(c) != b)
				r = BUF_W'(c);
		end
		return r;
	endfunction

	logic [BUF_W-1:0]  writing_q, ready_q, presenting_q;
	logic              new_frame_q;
	logic [CNT_W-1:0]  completed_q, shown_q, lost_q;
	logic [LUMA_W-1:0] pub_center_q, pub_probe_q, pend_center_q, pend_probe_q;

	logic [BUF_W-1:0]  writing_n, ready_n, presenting_n;
	logic              new_frame_n;
	logic [CNT_W-1:0]  completed_n, shown_n, lost_n;
	logic [LUMA_W-1:0] pub_center_n, pub_probe_n, pend_center_n, pend_probe_n;
	logic              wv_n, done_n;

	logic              out_valid_q, wv_q, done_q;
	logic [BUF_W-1:0]  wb_q;
	logic [IDX_W-1:0]  pidx_q;

	assign pop = !empty && (!out_valid_q || !out_stall);

	always_comb begin
		writing_n     = writing_q;
		ready_n       = ready_q;
		presenting_n  = presenting_q;
		new_frame_n   = new_frame_q;
		completed_n   = completed_q;
		shown_n       = shown_q;
		lost_n        = lost_q;
		pub_center_n  = pub_center_q;
		pub_probe_n   = pub_probe_q;
		pend_center_n = pend_center_q;
		pend_probe_n  = pend_probe_q;
		wv_n          = 1'b0;
		done_n        = 1'b0;
		unique case (head_cmd.kind)
			CMD_PIXEL: begin
				wv_n = 1'b1;
				if (head_cmd.hit_center)
					pend_center_n = head_cmd.luma;
				if (head_cmd.hit_probe)
					pend_probe_n = head_cmd.luma;
				if (head_cmd.last) begin
					done_n = 1'b1;
					if (new_frame_q)
						lost_n = lost_q + CNT_W'(1);
					ready_n      = writing_q;
					new_frame_n  = 1'b1;
					writing_n    = pick_free(presenting_q, writing_q);
					pub_center_n = pend_center_n;
					pub_probe_n  = pend_probe_n;
					completed_n  = completed_q + CNT_W'(1);
				end
			end
			CMD_PRESENT: begin
				if (new_frame_q) begin
					presenting_n = ready_q;
					new_frame_n  = 1'b0;
					shown_n      = shown_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			writing_q     <= WRITE_BUF_RESET;
			ready_q       <= '0;
			presenting_q  <= '0;
			new_frame_q   <= 1'b0;
			completed_q   <= '0;
			shown_q       <= '0;
			lost_q        <= '0;
			pub_center_q  <= '0;
			pub_probe_q   <= '0;
			pend_center_q <= '0;
			pend_probe_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				writing_q     <= writing_n;
				ready_q       <= ready_n;
				presenting_q  <= presenting_n;
				new_frame_q   <= new_frame_n;
				completed_q   <= completed_n;
				shown_q       <= shown_n;
				lost_q        <= lost_n;
				pub_center_q  <= pub_center_n;
				pub_probe_q   <= pub_probe_n;
				pend_center_q <= pend_center_n;
				pend_probe_q  <= pend_probe_n;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload; state registers above already hold the counter values
	always_ff @(posedge clk) begin
		if (pop) begin
			wv_q   <= wv_n;
			done_q <= done_n;
			wb_q   <= wv_n ? writing_q : '0;
			pidx_q <= wv_n ? head_cmd.index : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign write_valid      = wv_q;
	assign write_buffer     = wb_q;
	assign pixel_index      = pidx_q;
	assign frame_done       = done_q;
	assign present_buffer   = presenting_q;
	assign luma_center      = pub_center_q;
	assign luma_probe       = pub_probe_q;
	assign frames_completed = completed_q;
	assign presented_count  = shown_q;
	assign dropped_count    = lost_q;

	a_write_not_presented: assert property (@(posedge clk) disable iff (!arst_n)
		writing_q != presenting_q)
		else $error("writing buffer is the presented buffer");

	a_write_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		writing_q != ready_q)
		else $error("writing buffer is the ready buffer");

	a_done_counts: assert property (@(posedge clk) disable iff (!arst_n)
		pop && done_n |=> completed_q == $past(completed_q) + CNT_W'(1))
		else $error("frame completion not counted");

	a_present_swaps: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_cmd.kind == CMD_PRESENT && new_frame_q
		|=> !new_frame_q && presenting_q == $past(ready_q))
		else $error("present did not swap in the ready frame");

endmodule
